// ===== sv/zone_write_pointer_to_flash_address_defines.svh =====
// Assertion macros for the zone write pointer to flash address block.
// Depends on nothing; the asserting module provides clk and rst_n.
`ifndef ZONE_WRITE_POINTER_TO_FLASH_ADDRESS_DEFINES_SVH
`define ZONE_WRITE_POINTER_TO_FLASH_ADDRESS_DEFINES_SVH
`ifndef ASSERT_OFF
`define ZWPFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define ZWPFA_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define ZWPFA_ASSERT(lbl, prop)
`define ZWPFA_ASSERT_NR(lbl, prop)
`endif
`endif

// ===== sv/zwpfa_pkg.sv =====
// Shared constants for the zone write pointer to flash address block.
// Depends on nothing.
package zwpfa_pkg;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_GROUPS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LBAS_PER_PAGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_DIE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_BLK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_PLN = 3'd5;
endpackage

// ===== sv/zwpfa_div_cell.sv =====
// One restoring division step with its pipeline register.
// Depends on nothing.
module zwpfa_div_cell #(
  parameter int NW = 32,
  parameter int DW = 8,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [DW-1:0] r_i,
  input  logic [NW-1:0] x_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] s_i,
  output logic          v_o,
  output logic [DW-1:0] r_o,
  output logic [NW-1:0] x_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] s_o
);
  logic          v_r;
  logic [DW-1:0] r_r, r_nxt, d_r;
  logic [NW-1:0] x_r, x_nxt;
  logic [SW-1:0] s_r;
  logic [DW:0]   t, diff;
  logic          ge;

  always_comb begin
    t     = {r_i, x_i[NW-1]};
    diff  = t - {1'b0, d_i};
    ge    = (t >= {1'b0, d_i});
    r_nxt = ge ? diff[DW-1:0] : t[DW-1:0];
    x_nxt = {x_i[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      x_r <= x_nxt;
      d_r <= d_i;
      s_r <= s_i;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;
  assign x_o = x_r;
  assign d_o = d_r;
  assign s_o = s_r;
endmodule

// ===== sv/zwpfa_div.sv =====
// Pipelined divider built as a chain of division step cells, one quotient bit per cell.
// Depends on zwpfa_div_cell.
module zwpfa_div #(
  parameter int NW = 32,
  parameter int DW = 8,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] s_i,
  output logic          v_o,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] s_o
);
  logic          v_w [NW+1];
  logic [DW-1:0] r_w [NW+1];
  logic [NW-1:0] x_w [NW+1];
  logic [DW-1:0] d_w [NW+1];
  logic [SW-1:0] s_w [NW+1];

  assign v_w[0] = v_i;
  assign r_w[0] = '0;
  assign x_w[0] = num;
  assign d_w[0] = den;
  assign s_w[0] = s_i;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    zwpfa_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(v_w[i]), .r_i(r_w[i]), .x_i(x_w[i]), .d_i(d_w[i]), .s_i(s_w[i]),
      .v_o(v_w[i+1]), .r_o(r_w[i+1]), .x_o(x_w[i+1]), .d_o(d_w[i+1]),
      .s_o(s_w[i+1])
    );
  end

  assign v_o = v_w[NW];
  assign quo = x_w[NW];
  assign rem = r_w[NW];
  assign s_o = s_w[NW];
endmodule

// ===== sv/zone_write_pointer_to_flash_address.sv =====
// Top level: maps a zone index and write pointer to a flash page address.
// Depends on zwpfa_pkg, zwpfa_div and the assertion macro header.
//
// Usage: a request transaction on in_valid/in_ready carries in_zone_index and
// in_write_pointer. One result transaction on out_valid/out_ready follows for
// each request, in order, with channel, die, plane, block and page.
// Geometry registers are written on the cfg channel (cfg_ready is always high);
// cfg_index selects the register, cfg_data the value. The user must write them
// only while the block is idle; the block itself does not enforce it.
// Throughput is one transaction per cycle while the receiver does not stall.
// It uses six chained bit-serial dividers for the register divisors, one
// quotient bit per cell per cycle, plus a two-stage reciprocal multiply for
// the division by DIES_PER_GROUP.
// When the receiver stalls with a result pending, the whole chain holds and
// in_ready drops; it resumes the cycle the result is taken.
// Reset empties the pipeline and loads the default geometry.
`include "zone_write_pointer_to_flash_address_defines.svh"
module zone_write_pointer_to_flash_address #(
  parameter int DIES_PER_GROUP = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_zone_index,
  input  logic [31:0] in_write_pointer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_channel,
  output logic [21:0] out_die_in_channel,
  output logic [7:0]  out_plane,
  output logic [15:0] out_block_in_plane,
  output logic [15:0] out_page_in_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [zwpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zwpfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int GW   = $clog2(DIES_PER_GROUP + 1);
  localparam int DIEW = 16 + GW;
  localparam int RSH  = 32 + $clog2(DIES_PER_GROUP);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << RSH) + 64'(DIES_PER_GROUP) - 64'd1) / 64'(DIES_PER_GROUP));

  logic [12:0] bg_r;
  logic [6:0]  lpp_r, nch_r;
  logic [15:0] bpd_r, ppb_r, bpp_r;
  logic [12:0] bg;
  logic [6:0]  lpp, nch;
  logic [15:0] ppb, bpp;
  logic        en;

  assign cfg_ready = 1'b1;
  assign bg  = (bg_r  == '0) ? 13'd1 : bg_r;
  assign lpp = (lpp_r == '0) ? 7'd1  : lpp_r;
  assign nch = (nch_r == '0) ? 7'd1  : nch_r;
  assign ppb = (ppb_r == '0) ? 16'd1 : ppb_r;
  assign bpp = (bpp_r == '0) ? 16'd1 : bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r  <= 13'd1;
      lpp_r <= 7'd8;
      nch_r <= 7'd8;
      bpd_r <= 16'd256;
      ppb_r <= 16'd256;
      bpp_r <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        zwpfa_pkg::REG_BLOCK_GROUPS:   bg_r  <= cfg_data[12:0];
        zwpfa_pkg::REG_LBAS_PER_PAGE:  lpp_r <= cfg_data[6:0];
        zwpfa_pkg::REG_NUM_CHANNELS:   nch_r <= cfg_data[6:0];
        zwpfa_pkg::REG_BLOCKS_PER_DIE: bpd_r <= cfg_data;
        zwpfa_pkg::REG_PAGES_PER_BLK:  ppb_r <= cfg_data;
        zwpfa_pkg::REG_BLOCKS_PER_PLN: bpp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Page number.
  logic        v1;
  logic [31:0] page;
  logic [6:0]  rem1;
  logic [15:0] zone1;
  zwpfa_div #(.NW(32), .DW(7), .SW(16)) u_d1 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_valid && in_ready),
    .num(in_write_pointer), .den(lpp), .s_i(in_zone_index),
    .v_o(v1), .quo(page), .rem(rem1), .s_o(zone1)
  );

  // Page within block group and die offset within the group, by a rounded-up
  // reciprocal of the constant group size split into two partial products.
  logic          ra_v_r;
  logic [47:0]   ra_lo_r;
  logic [48:0]   ra_hi_r;
  logic [GW-1:0] ra_pm_r;
  logic [15:0]   ra_zone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_v_r <= 1'b0;
    end else if (en) begin
      ra_v_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_lo_r   <= 48'(page) * 48'(RECIP[15:0]);
      ra_hi_r   <= 49'(page) * 49'(RECIP[32:16]);
      ra_pm_r   <= page[GW-1:0];
      ra_zone_r <= zone1;
    end
  end

  logic [64:0]   rprod;
  logic [31:0]   rq;
  logic          rb_v_r;
  logic [31:0]   rb_q_r;
  logic [GW-1:0] rb_pm_r;
  logic [15:0]   rb_zone_r;
  assign rprod = {ra_hi_r, 16'd0} + 65'(ra_lo_r);
  assign rq    = 32'(rprod >> RSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_v_r <= 1'b0;
    end else if (en) begin
      rb_v_r <= ra_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rb_q_r    <= rq;
      rb_pm_r   <= ra_pm_r - GW'(rq * 32'(DIES_PER_GROUP));
      rb_zone_r <= ra_zone_r;
    end
  end

  logic          v2;
  logic [31:0]   pgbg;
  logic [GW-1:0] pm;
  logic [15:0]   zone2;
  assign v2    = rb_v_r;
  assign pgbg  = rb_q_r;
  assign pm    = rb_pm_r;
  assign zone2 = rb_zone_r;

  // Die group and block group of the zone.
  logic        v3;
  logic [15:0] zq;
  logic [12:0] zr;
  logic [31:0] pgbg3;
  logic [GW-1:0] pm3;
  zwpfa_div #(.NW(16), .DW(13), .SW(32+GW)) u_d3 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v2),
    .num(zone2), .den(bg), .s_i({pgbg, pm}),
    .v_o(v3), .quo(zq), .rem(zr), .s_o({pgbg3, pm3})
  );

  // Blocks per block group.
  logic        v4;
  logic [15:0] bpb, zq4;
  logic [12:0] rem4, zr4;
  logic [31:0] pgbg4;
  logic [GW-1:0] pm4;
  zwpfa_div #(.NW(16), .DW(13), .SW(32+GW+16+13)) u_d4 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v3),
    .num(bpd_r), .den(bg), .s_i({pgbg3, pm3, zq, zr}),
    .v_o(v4), .quo(bpb), .rem(rem4), .s_o({pgbg4, pm4, zq4, zr4})
  );

  // Block within the group and page within the block.
  logic        v5;
  logic [31:0] bq;
  logic [15:0] pib, zq5, bpb5;
  logic [12:0] zr5;
  logic [GW-1:0] pm5;
  zwpfa_div #(.NW(32), .DW(16), .SW(GW+16+13+16)) u_d5 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v4),
    .num(pgbg4), .den(ppb), .s_i({pm4, zq4, zr4, bpb}),
    .v_o(v5), .quo(bq), .rem(pib), .s_o({pm5, zq5, zr5, bpb5})
  );

  // Absolute block and die number.
  logic            m_v_r;
  logic [32:0]     abs_r;
  logic [DIEW-1:0] die_r;
  logic [15:0]     pib_r;
  logic [28:0]     prod;
  assign prod = zr5 * bpb5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_r <= {4'd0, prod} + {1'b0, bq};
      die_r <= DIEW'(zq5) * DIEW'(DIES_PER_GROUP) + DIEW'(pm5);
      pib_r <= pib;
    end
  end

  // Channel and die within channel.
  logic            v6;
  logic [DIEW-1:0] dq;
  logic [6:0]      dr;
  logic [32:0]     abs6;
  logic [15:0]     pib6;
  zwpfa_div #(.NW(DIEW), .DW(7), .SW(33+16)) u_d6 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(m_v_r),
    .num(die_r), .den(nch), .s_i({abs_r, pib_r}),
    .v_o(v6), .quo(dq), .rem(dr), .s_o({abs6, pib6})
  );

  // Plane and block within plane.
  logic            v7;
  logic [32:0]     aq;
  logic [15:0]     ar, pib7;
  logic [DIEW-1:0] dq7;
  logic [6:0]      dr7;
  zwpfa_div #(.NW(33), .DW(16), .SW(DIEW+7+16)) u_d7 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v6),
    .num(abs6), .den(bpp), .s_i({dq, dr, pib6}),
    .v_o(v7), .quo(aq), .rem(ar), .s_o({dq7, dr7, pib7})
  );

  logic [22:0] dq23;
  assign dq23 = 23'(dq7);

  logic [5:0]  ch_r;
  logic [21:0] dic_r;
  logic [7:0]  pl_r;
  logic [15:0] bip_r, pgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r  <= (dr7 > 7'd63) ? 6'd63 : dr7[5:0];
      dic_r <= (dq23 > 23'h3FFFFF) ? 22'h3FFFFF : dq23[21:0];
      pl_r  <= (aq > 33'd255) ? 8'd255 : aq[7:0];
      bip_r <= ar;
      pgb_r <= pib7;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = ch_r;
  assign out_die_in_channel = dic_r;
  assign out_plane          = pl_r;
  assign out_block_in_plane = bip_r;
  assign out_page_in_block  = pgb_r;

  `ZWPFA_ASSERT_NR(a_reset_empty, !rst_n |=> !out_valid_r && !m_v_r)
  `ZWPFA_ASSERT(a_stall_only_full, !in_ready |-> out_valid_r)
  `ZWPFA_ASSERT(a_mid_holds, m_v_r && !en |=> m_v_r)
endmodule

// ===== verif/zone_write_pointer_to_flash_address_tb.sv =====
// Self-checking testbench for the zone write pointer to flash address block.
// Depends on zwpfa_pkg and zone_write_pointer_to_flash_address; predicts each
// address in the testbench and compares every result transaction in order.
module zone_write_pointer_to_flash_address_tb;
  localparam int GROUP_DIES = 4;
  localparam int LATENCY = 32 + 2 + 16 + 16 + 32 + 1 + (16 + $clog2(GROUP_DIES + 1)) + 33 + 1;
  localparam int STALL_LIMIT = 20 * LATENCY + 2000;
  localparam logic [zwpfa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [zwpfa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [15:0] zone;
    logic [31:0] wptr;
  } request_t;

  typedef struct packed {
    logic [5:0]  channel;
    logic [21:0] die;
    logic [7:0]  plane;
    logic [15:0] block;
    logic [15:0] page;
  } address_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_zone_index = '0;
  logic [31:0] in_write_pointer = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_channel;
  logic [21:0] out_die_in_channel;
  logic [7:0] out_plane;
  logic [15:0] out_block_in_plane;
  logic [15:0] out_page_in_block;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [zwpfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [zwpfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  zone_write_pointer_to_flash_address #(.DIES_PER_GROUP(GROUP_DIES)) uut (.*);

  always #4 clk = ~clk;

  logic [12:0] geo_groups;
  logic [6:0]  geo_lpp;
  logic [6:0]  geo_chans;
  logic [15:0] geo_bpd;
  logic [15:0] geo_ppb;
  logic [15:0] geo_bpp;

  request_t pending_requests[$];
  address_t expected_addresses[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  function automatic longint unsigned at_least_one(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic address_t map_address(request_t r);
    longint unsigned grp, lpp, nch, ppb, bpp, pg, die, pg_in_grp, blk;
    address_t a;
    grp = at_least_one(geo_groups);
    lpp = at_least_one(geo_lpp);
    nch = at_least_one(geo_chans);
    ppb = at_least_one(geo_ppb);
    bpp = at_least_one(geo_bpp);
    pg = r.wptr / lpp;
    die = (r.zone / grp) * GROUP_DIES + pg % GROUP_DIES;
    pg_in_grp = pg / GROUP_DIES;
    blk = (r.zone % grp) * (geo_bpd / grp) + pg_in_grp / ppb;
    a.channel = (die % nch > 63) ? 6'd63 : 6'(die % nch);
    a.die = (die / nch > 22'h3FFFFF) ? 22'h3FFFFF : 22'(die / nch);
    a.plane = (blk / bpp > 255) ? 8'd255 : 8'(blk / bpp);
    a.block = 16'(blk % bpp);
    a.page = 16'(pg_in_grp % ppb);
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        expected_addresses.push_back(map_address({in_zone_index, in_write_pointer}));
      end
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_zone_index <= r.zone;
        in_write_pointer <= r.wptr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    address_t got, want;
    if (rst_n) begin
      got = {out_channel, out_die_in_channel, out_plane, out_block_in_plane,
             out_page_in_block};
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_addresses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction %p", got);
        end else begin
          want = expected_addresses.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("Timeout with %0d results outstanding", expected_addresses.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_register(logic [zwpfa_pkg::CFG_IDX_W-1:0] idx,
                                logic [zwpfa_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      zwpfa_pkg::REG_BLOCK_GROUPS:   geo_groups = val[12:0];
      zwpfa_pkg::REG_LBAS_PER_PAGE:  geo_lpp = val[6:0];
      zwpfa_pkg::REG_NUM_CHANNELS:   geo_chans = val[6:0];
      zwpfa_pkg::REG_BLOCKS_PER_DIE: geo_bpd = val;
      zwpfa_pkg::REG_PAGES_PER_BLK:  geo_ppb = val;
      zwpfa_pkg::REG_BLOCKS_PER_PLN: geo_bpp = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(int grp, int lpp, int nch, int bpd, int ppb, int bpp);
    write_register(zwpfa_pkg::REG_BLOCK_GROUPS, 16'(grp));
    write_register(zwpfa_pkg::REG_LBAS_PER_PAGE, 16'(lpp));
    write_register(zwpfa_pkg::REG_NUM_CHANNELS, 16'(nch));
    write_register(zwpfa_pkg::REG_BLOCKS_PER_DIE, 16'(bpd));
    write_register(zwpfa_pkg::REG_PAGES_PER_BLK, 16'(ppb));
    write_register(zwpfa_pkg::REG_BLOCKS_PER_PLN, 16'(bpp));
  endtask

  task automatic drain;
    while (pending_requests.size() > 0 || in_valid || expected_addresses.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    request_t r;
    for (int i = 0; i < count; i++) begin
      r.zone = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64));
      case ($urandom_range(3))
        0: r.wptr = $urandom;
        1: r.wptr = $urandom_range(4095);
        default: r.wptr = $urandom_range(1 << 20);
      endcase
      pending_requests.push_back(r);
    end
  endtask

  initial begin
    geo_groups = 13'd1; geo_lpp = 7'd8; geo_chans = 7'd8;
    geo_bpd = 16'd256; geo_ppb = 16'd256; geo_bpp = 16'd256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 48;
    pending_requests.push_back('{16'd0, 32'd0});
    pending_requests.push_back('{16'hFFFF, 32'hFFFF_FFFF});
    pending_requests.push_back('{16'd1, 32'd7});
    pending_requests.push_back('{16'd5, 32'd8});
    pending_requests.push_back('{16'hAAAA, 32'h5555_5555});
    pending_requests.push_back('{16'h5555, 32'hAAAA_AAAA});
    drain();

    set_geometry(0, 0, 0, 0, 0, 0);
    write_register(REG_UNMAPPED_LO, 16'hFFFF);
    write_register(REG_UNMAPPED_HI, 16'h1234);
    pending_requests.push_back('{16'hFFFF, 32'hFFFF_FFFF});
    pending_requests.push_back('{16'h1234, 32'd99});
    drain();

    set_geometry(4096, 64, 64, 65535, 65535, 65535);
    pending_requests.push_back('{16'hFFFF, 32'hFFFF_FFFF});
    pending_requests.push_back('{16'd4097, 32'd1});
    drain();
    set_geometry(8191, 127, 127, 65535, 1, 1);
    pending_requests.push_back('{16'hFFFF, 32'hFFFF_FFFF});
    pending_requests.push_back('{16'd8190, 32'h0FFF_0000});
    pending_requests.push_back('{16'd3, 32'd1024});
    drain();

    set_geometry(1, 1, 1, 65535, 1, 1);
    pending_requests.push_back('{16'hFFFF, 32'hFFFF_FFFF});
    pending_requests.push_back('{16'd0, 32'hFFFF_FFFF});
    queue_random(200);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 8;
    set_geometry(16, 4, 3, 1024, 64, 8);
    queue_random(200);
    drain();
    set_geometry(4, 8, 16, 2, 16, 1);
    queue_random(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry($urandom_range(1, 4096), $urandom_range(1, 64), $urandom_range(1, 64),
                 $urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(1, 65535));
    queue_random(200);
    drain();
    set_geometry(3, 64, 5, 300, 7, 300);
    queue_random(200);
    drain();

    $display("Checked %0d address results over nine geometry settings,", results_seen);
    $display("including zero and maximum register values and saturating fields.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
